### hdl/uuidp_pkg.sv
// Package: shared types, constants and hex decode for the UUID text parser.
`default_nettype none
package uuidp_pkg;

  localparam int unsigned CountW = 6;
  localparam int unsigned NibW = 4;
  localparam int unsigned HalfW = 64;

  localparam logic [CountW-1:0] STD_LEN = CountW'(36);
  localparam logic [CountW-1:0] LEG_LEN = CountW'(35);
  localparam logic [CountW-1:0] COUNT_MAX = CountW'(37);

  localparam logic [CountW-1:0] SEP_A = CountW'(8);
  localparam logic [CountW-1:0] SEP_B = CountW'(13);
  localparam logic [CountW-1:0] SEP_C = CountW'(18);
  localparam logic [CountW-1:0] SEP_D = CountW'(23);

  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LF = 8'h66;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UF = 8'h46;

  typedef enum logic [2:0] {
    ST_STD_OK   = 3'd0,
    ST_LEG_OK   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BAD_LEN  = 3'd3,
    ST_BAD_DIG  = 3'd4
  } status_t;

  typedef struct packed {
    logic            std_digit;
    logic            leg_digit;
    logic            is_hex;
    logic [NibW-1:0] nib;
  } decode_t;

  function automatic logic [NibW:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'h00;
      if (c >= CH_0 && c <= CH_9) begin
        d = c - CH_0;
        hex_value = {1'b1, d[NibW-1:0]};
      end else if (c >= CH_LA && c <= CH_LF) begin
        d = c - CH_LA + 8'd10;
        hex_value = {1'b1, d[NibW-1:0]};
      end else if (c >= CH_UA && c <= CH_UF) begin
        d = c - CH_UA + 8'd10;
        hex_value = {1'b1, d[NibW-1:0]};
      end else begin
        hex_value = {1'b0, d[NibW-1:0]};
      end
    end
  endfunction

endpackage
`default_nettype wire

### hdl/uuidp_decode.sv
// Character decode: hex value and digit-position flags for both layouts.
`default_nettype none
module uuidp_decode
  import uuidp_pkg::*;
(
  input  wire logic [7:0]        ch,
  input  wire logic [CountW-1:0] pos,
  output decode_t                dec
);

  logic [NibW:0] hv;
  logic          leg_sep;
  logic          std_sep;

  always_comb begin
    hv = hex_value(ch);
    leg_sep = (pos == SEP_A) || (pos == SEP_B) || (pos == SEP_C);
    std_sep = leg_sep || (pos == SEP_D);
    dec.std_digit = (pos < STD_LEN) && !std_sep;
    dec.leg_digit = (pos < LEG_LEN) && !leg_sep;
    dec.is_hex = hv[NibW];
    dec.nib = hv[NibW-1:0];
  end

endmodule
`default_nettype wire

### hdl/uuid_text_parser.sv
// Top level: UUID text parser with input register, both-layout accumulators, result register.
// Takes one character beat per cycle and gives one result beat when a string ends:
// the 128-bit identifier as id_high/id_low plus a status (standard 36-character
// layout, legacy 35-character layout without the last separator, empty string,
// bad length, bad digit). Each beat passes an input register, then decode and shift
// into both readings; the result for the last beat of a string is then written
// into the output register, once that register is free to take it. A new beat is
// taken every cycle; the input stalls only while a finished result still waits
// in the output register and the registered beat is itself the end of a string.
`default_nettype none
module uuid_text_parser
  import uuidp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        ch,
  input  wire logic              end_of_string,
  input  wire logic              no_char,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [HalfW-1:0]       id_high,
  output logic [HalfW-1:0]       id_low,
  output logic [2:0]             status,
  output logic                   accepted
);

  // input register
  logic              s1_valid;
  logic [7:0]        s1_ch;
  logic              s1_last;
  logic              s1_none;

  // parse state
  logic [CountW-1:0]  char_count;
  logic [2*HalfW-1:0] standard_accum;
  logic [2*HalfW-1:0] legacy_accum;
  logic               standard_bad;
  logic               legacy_bad;

  logic [CountW-1:0]  char_count_next;
  logic [2*HalfW-1:0] standard_accum_next;
  logic [2*HalfW-1:0] legacy_accum_next;
  logic               standard_bad_next;
  logic               legacy_bad_next;

  logic               take;
  logic               out_free;
  logic               s1_go;
  decode_t            dec;
  status_t            res_status;
  logic [2*HalfW-1:0] res_id;

  uuidp_decode u_decode (
    .ch  (s1_ch),
    .pos (char_count),
    .dec (dec)
  );

  always_comb begin
    out_free = !out_valid || !out_stall;
    s1_go = s1_valid && (!s1_last || out_free);
    in_stall = s1_valid && !s1_go;
    take = !s1_none && (char_count < COUNT_MAX);

    char_count_next = char_count;
    standard_accum_next = standard_accum;
    legacy_accum_next = legacy_accum;
    standard_bad_next = standard_bad;
    legacy_bad_next = legacy_bad;
    if (take) begin
      char_count_next = char_count + CountW'(1);
      if (dec.std_digit) begin
        if (dec.is_hex) begin
          standard_accum_next = {standard_accum[2*HalfW-NibW-1:0], dec.nib};
        end else begin
          standard_bad_next = 1'b1;
        end
      end
      if (dec.leg_digit) begin
        if (dec.is_hex) begin
          legacy_accum_next = {legacy_accum[2*HalfW-NibW-1:0], dec.nib};
        end else begin
          legacy_bad_next = 1'b1;
        end
      end
    end

    res_id = '0;
    priority if (char_count_next == '0) begin
      res_status = ST_EMPTY;
    end else if (char_count_next == STD_LEN) begin
      if (standard_bad_next) begin
        res_status = ST_BAD_DIG;
      end else begin
        res_status = ST_STD_OK;
        res_id = standard_accum_next;
      end
    end else if (char_count_next == LEG_LEN) begin
      if (legacy_bad_next) begin
        res_status = ST_BAD_DIG;
      end else begin
        res_status = ST_LEG_OK;
        res_id = legacy_accum_next;
      end
    end else begin
      res_status = ST_BAD_LEN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_ch <= ch;
      s1_last <= end_of_string;
      s1_none <= no_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= '0;
      standard_accum <= '0;
      legacy_accum <= '0;
      standard_bad <= 1'b0;
      legacy_bad <= 1'b0;
    end else if (s1_go) begin
      if (s1_last) begin
        char_count <= '0;
        standard_accum <= '0;
        legacy_accum <= '0;
        standard_bad <= 1'b0;
        legacy_bad <= 1'b0;
      end else begin
        char_count <= char_count_next;
        standard_accum <= standard_accum_next;
        legacy_accum <= legacy_accum_next;
        standard_bad <= standard_bad_next;
        legacy_bad <= legacy_bad_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      id_high <= res_id[2*HalfW-1:HalfW];
      id_low <= res_id[HalfW-1:0];
      status <= res_status;
      accepted <= (res_status == ST_STD_OK) || (res_status == ST_LEG_OK) ||
                  (res_status == ST_EMPTY);
    end
  end

endmodule
`default_nettype wire

### tb/tb.sv
// Testbench for uuid_text_parser: directed and random UUID strings checked against a predictor.
`timescale 1ns / 100ps
module tb;
  import uuidp_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       eos;
    logic       blank;
  } beat_t;

  typedef struct {
    logic [HalfW-1:0] hi;
    logic [HalfW-1:0] lo;
    status_t          st;
    logic             ok;
  } id_result_t;

  class uuid_result_board;
    id_result_t        pending_ids[$];
    logic [CountW-1:0] n_chars;
    logic [127:0]      std_nibs;
    logic [127:0]      leg_nibs;
    logic              std_bad;
    logic              leg_bad;
    int                errors;
    int                checked;
    int                by_status[5];

    function new();
      clear();
      errors = 0;
      checked = 0;
      foreach (by_status[i]) by_status[i] = 0;
    endfunction

    function void clear();
      n_chars = '0;
      std_nibs = '0;
      leg_nibs = '0;
      std_bad = 1'b0;
      leg_bad = 1'b0;
    endfunction

    function bit to_nib(input logic [7:0] c, output logic [3:0] n);
      n = '0;
      if (c >= CH_0 && c <= CH_9) n = 4'(c - CH_0);
      else if (c >= CH_LA && c <= CH_LF) n = 4'(c - CH_LA + 8'd10);
      else if (c >= CH_UA && c <= CH_UF) n = 4'(c - CH_UA + 8'd10);
      else return 1'b0;
      return 1'b1;
    endfunction

    function int pending();
      return pending_ids.size();
    endfunction

    function void note_beat(beat_t b);
      logic [3:0] n;
      bit         hex;
      bit         std_sep;
      bit         leg_sep;
      id_result_t r;
      if (!b.blank && n_chars < COUNT_MAX) begin
        hex = to_nib(b.ch, n);
        leg_sep = (n_chars == SEP_A || n_chars == SEP_B || n_chars == SEP_C);
        std_sep = leg_sep || (n_chars == SEP_D);
        if (n_chars < STD_LEN && !std_sep) begin
          if (hex) std_nibs = {std_nibs[123:0], n};
          else std_bad = 1'b1;
        end
        if (n_chars < LEG_LEN && !leg_sep) begin
          if (hex) leg_nibs = {leg_nibs[123:0], n};
          else leg_bad = 1'b1;
        end
        n_chars++;
      end
      if (!b.eos) return;
      r.hi = '0;
      r.lo = '0;
      if (n_chars == 0) begin
        r.st = ST_EMPTY;
      end else if (n_chars == STD_LEN) begin
        if (std_bad) r.st = ST_BAD_DIG;
        else begin
          r.st = ST_STD_OK;
          {r.hi, r.lo} = std_nibs;
        end
      end else if (n_chars == LEG_LEN) begin
        if (leg_bad) r.st = ST_BAD_DIG;
        else begin
          r.st = ST_LEG_OK;
          {r.hi, r.lo} = leg_nibs;
        end
      end else begin
        r.st = ST_BAD_LEN;
      end
      r.ok = (r.st == ST_STD_OK || r.st == ST_LEG_OK || r.st == ST_EMPTY);
      pending_ids.push_back(r);
      clear();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic [63:0] hi, logic [63:0] lo, logic [2:0] st, logic ok);
      id_result_t e;
      if (pending_ids.size() == 0) begin
        report($sformatf("result beat with nothing pending, status %0d", st));
        return;
      end
      e = pending_ids.pop_front();
      checked++;
      by_status[int'(e.st)]++;
      if (hi !== e.hi) report($sformatf("id_high %h, want %h", hi, e.hi));
      if (lo !== e.lo) report($sformatf("id_low %h, want %h", lo, e.lo));
      if (st !== e.st) report($sformatf("status %0d, want %0d", st, e.st));
      if (ok !== e.ok) report($sformatf("accepted %b, want %b", ok, e.ok));
    endtask

    task flush_check();
      if (pending_ids.size() != 0)
        report($sformatf("%0d results never arrived", pending_ids.size()));
    endtask
  endclass

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        ch;
  logic              end_of_string;
  logic              no_char;
  logic              out_valid;
  logic              out_stall;
  logic [HalfW-1:0]  id_high;
  logic [HalfW-1:0]  id_low;
  logic [2:0]        status;
  logic              accepted;

  uuid_result_board  sb;
  logic [7:0]        txt[$];
  int                items_sent;
  int                strings_sent;
  int                burst_left;
  int                rx_hold;
  bit                tx_up;

  uuid_text_parser u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .ch            (ch),
    .end_of_string (end_of_string),
    .no_char       (no_char),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .id_high       (id_high),
    .id_low        (id_low),
    .status        (status),
    .accepted      (accepted)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(3_000_000);
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(id_high, id_low, status, accepted);
  end

  initial begin : rx_side
    int mode;
    int seg;
    int phase;
    mode = 0;
    seg = 0;
    phase = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      phase++;
      if (rx_hold > 0) begin
        out_stall <= 1'b1;
        rx_hold--;
      end else begin
        if (seg == 0) begin
          mode = $urandom_range(0, 3);
          seg = $urandom_range(10, 150);
        end
        seg--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 1);
          default: out_stall <= (phase % 5 < 3);
        endcase
      end
    end
  end

  function automatic bit at_sep(int p, bit legacy);
    return p == SEP_A || p == SEP_B || p == SEP_C || (!legacy && p == SEP_D);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n, bit up);
    if (n < 10) return CH_0 + 8'(n);
    return (up ? CH_UA : CH_LA) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] c;
    logic [3:0] n;
    do c = 8'($urandom_range(0, 255)); while (sb.to_nib(c, n));
    return c;
  endfunction

  function automatic int digit_pos(bit legacy);
    int p;
    do p = $urandom_range(0, legacy ? 34 : 35); while (at_sep(p, legacy));
    return p;
  endfunction

  function automatic logic [127:0] rand_id();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  task automatic put_uuid(bit legacy, logic [127:0] v, int letter_case);
    int j;
    bit up;
    txt.delete();
    j = 0;
    for (int p = 0; p < (legacy ? 35 : 36); p++) begin
      if (at_sep(p, legacy)) begin
        txt.push_back("-");
      end else begin
        up = (letter_case == 2) ? $urandom_range(0, 1) : letter_case;
        txt.push_back(hex_char(v[4*(31-j) +: 4], up));
        j++;
      end
    end
  endtask

  task automatic put_random(int len, bit hex_only);
    txt.delete();
    for (int p = 0; p < len; p++) begin
      if (hex_only) txt.push_back(hex_char(4'($urandom), $urandom_range(0, 1)));
      else txt.push_back(8'($urandom));
    end
  endtask

  task automatic send_beat(beat_t b);
    int gap;
    in_valid <= 1'b1;
    tx_up = 1'b1;
    ch <= b.ch;
    end_of_string <= b.eos;
    no_char <= b.blank;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_beat(b);
    if (!b.blank || b.eos) items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(100, 300);
      else burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        tx_up = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_text(bit tail_blank, int noise);
    beat_t b;
    for (int i = 0; i < txt.size(); i++) begin
      if (noise > 0 && $urandom_range(0, 99) < noise) begin
        b.ch = 8'($urandom);
        b.eos = 1'b0;
        b.blank = 1'b1;
        send_beat(b);
      end
      b.ch = txt[i];
      b.blank = 1'b0;
      b.eos = (i == txt.size() - 1) && !tail_blank;
      send_beat(b);
    end
    if (tail_blank || txt.size() == 0) begin
      b.ch = 8'($urandom);
      b.eos = 1'b1;
      b.blank = 1'b1;
      send_beat(b);
    end
    strings_sent++;
  endtask

  task automatic wait_drained();
    if (tx_up) begin
      in_valid <= 1'b0;
      tx_up = 1'b0;
    end
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    beat_t      b;
    logic [7:0] near_hex[6];
    bit         legacy;
    int         kind;
    int         n;
    sb = new();
    near_hex = '{8'h2f, 8'h3a, 8'h40, 8'h47, 8'h60, 8'h67};
    items_sent = 0;
    strings_sent = 0;
    burst_left = 0;
    rx_hold = 0;
    tx_up = 1'b0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    ch <= 8'h00;
    end_of_string <= 1'b0;
    no_char <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    txt.delete();
    send_text(1'b0, 0);
    put_uuid(1'b0, 128'h0123456789abcdeffedcba9876543210, 0);
    send_text(1'b0, 0);
    put_uuid(1'b0, '1, 1);
    send_text(1'b0, 0);
    put_uuid(1'b1, '0, 2);
    send_text(1'b0, 0);
    put_uuid(1'b1, 128'hfedcba98765432100123456789abcdef, 2);
    send_text(1'b0, 0);
    put_uuid(1'b0, rand_id(), 2);
    txt[8] = 8'h00;
    txt[13] = 8'hff;
    txt[18] = "g";
    txt[23] = " ";
    send_text(1'b0, 0);
    put_uuid(1'b0, rand_id(), 0);
    txt[35] = "g";
    send_text(1'b0, 0);
    put_uuid(1'b0, rand_id(), 1);
    txt[0] = 8'h00;
    send_text(1'b0, 0);
    put_uuid(1'b1, rand_id(), 0);
    txt[23] = "-";
    send_text(1'b0, 0);
    put_uuid(1'b1, rand_id(), 1);
    txt[34] = 8'hff;
    send_text(1'b0, 0);
    put_uuid(1'b0, rand_id(), 0);
    txt.push_back("0");
    send_text(1'b0, 0);
    put_random(40, 1'b0);
    foreach (txt[i]) txt[i] = "z";
    send_text(1'b0, 0);
    put_random(1, 1'b1);
    send_text(1'b0, 0);
    put_random(34, 1'b1);
    send_text(1'b0, 0);
    put_uuid(1'b0, rand_id(), 2);
    send_text(1'b1, 20);
    for (int i = 0; i < 3; i++) begin
      b.ch = 8'($urandom);
      b.eos = 1'b0;
      b.blank = 1'b1;
      send_beat(b);
    end
    txt.delete();
    send_text(1'b0, 0);
    foreach (near_hex[i]) begin
      legacy = i % 2;
      put_uuid(legacy, rand_id(), 2);
      txt[digit_pos(legacy)] = near_hex[i];
      send_text(1'b0, 0);
    end
    wait_drained();

    while (items_sent < 1250) begin
      if (strings_sent == 26) rx_hold = 400;
      if (strings_sent == 32 || $urandom_range(0, 29) == 0) wait_drained();
      kind = $urandom_range(0, 99);
      legacy = (kind >= 40 && kind < 65) || (kind >= 65 && $urandom_range(0, 1) == 1);
      if (kind < 77) begin
        put_uuid(legacy, rand_id(), $urandom_range(0, 2));
        foreach (txt[p]) begin
          if (at_sep(p, legacy) && $urandom_range(0, 4) == 0) txt[p] = 8'($urandom);
        end
        if (kind >= 65) txt[digit_pos(legacy)] = non_hex();
      end else begin
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(34, 37) : $urandom_range(0, 40);
        put_random(n, kind < 87);
      end
      send_text($urandom_range(0, 9) == 0, ($urandom_range(0, 3) == 0) ? 5 : 0);
    end

    if (tx_up) begin
      in_valid <= 1'b0;
      tx_up = 1'b0;
    end
    n = 0;
    while (sb.pending() != 0 && n < 20000) begin
      @(posedge clk);
      n++;
    end
    repeat (8) @(posedge clk);
    sb.flush_check();
    $display("Parsed %0d strings (%0d beats), %0d results compared", strings_sent,
             items_sent, sb.checked);
    $display("  standard %0d, legacy %0d, empty %0d, wrong length %0d, bad digit %0d",
             sb.by_status[0], sb.by_status[1], sb.by_status[2], sb.by_status[3],
             sb.by_status[4]);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
